// ===== rtl/core/pf_pkg.sv =====
// pf_pkg: shared field widths for the prime factorizer
// no dependencies; compiled first
`default_nettype none

package pf_pkg;

   // fixed widths of the item fields
   localparam int VALUE_W  = 32;
   localparam int FACTOR_W = 32;

endpackage : pf_pkg

`default_nettype wire

// ===== rtl/core/pf_if.sv =====
// pf_req_if / pf_rsp_if: valid-ready channels of the prime factorizer
// depends on pf_pkg for the field widths
`default_nettype none

interface pf_req_if;
   import pf_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface : pf_req_if

interface pf_rsp_if;
   import pf_pkg::*;

   logic                valid;
   logic                ready;
   logic [FACTOR_W-1:0] factor;
   logic                last;
   logic                empty_res;

   modport source (output valid, output factor, output last, output empty_res, input ready);
   modport sink   (input valid, input factor, input last, input empty_res, output ready);
endinterface : pf_rsp_if

`default_nettype wire

// ===== rtl/core/prime_factorizer.sv =====
// prime_factorizer: trial-division factorization with a bit-serial divider
// depends on pf_pkg and the pf_req_if / pf_rsp_if interfaces
// division: each trial division shifts out one quotient bit per cycle, then
//   decides in ST_CHECK; QW = min(VALUE_BITS, 32)
// throughput: one item at a time; the next item is taken once the last
//   result of the previous one has been loaded into the output register
// reset: synchronous, active high; clears the sequencer and the output valid
`default_nettype none

module prime_factorizer #(
   parameter int VALUE_BITS = 32
) (
   input  wire     clock,
   input  wire     reset,
   pf_req_if.sink   req_if,
   pf_rsp_if.source rsp_if
);
   import pf_pkg::*;

   // working width of the quotient and of the trial divisor
   localparam int QW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
   localparam int DW = QW / 2 + 1;
   localparam int CW = $clog2(QW);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_CHECK
   } state_type;

   state_type           st_ff, st_in;
   logic [QW-1:0]       q_ff, q_in;       // remaining quotient
   logic [DW-1:0]       d_ff, d_in;       // trial divisor
   logic [QW-1:0]       work_ff, work_in; // dividend shifts out, quotient shifts in
   logic [DW-1:0]       rem_ff, rem_in;   // partial remainder, below d during a division
   logic [CW-1:0]       cnt_ff, cnt_in;   // quotient bits still to go, less one

   logic                rsp_valid_ff, rsp_valid_in;
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic                last_ff, last_in;
   logic                empty_ff, empty_in;

   logic                slot_free;
   logic [DW:0]         trial;            // remainder with next dividend bit shifted in
   logic [DW+1:0]       diff;
   logic                fits;
   logic [QW-1:0]       d_wide;

   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   // one restoring-division step: try subtracting d from the shifted remainder
   assign trial  = {rem_ff, work_ff[QW-1]};
   assign diff   = {1'b0, trial} - {2'b00, d_ff};
   assign fits   = !diff[DW+1];
   assign d_wide = {{(QW-DW){1'b0}}, d_ff};

   always_comb begin
      st_in        = st_ff;
      q_in         = q_ff;
      d_in         = d_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      factor_in    = factor_ff;
      last_in      = last_ff;
      empty_in     = empty_ff;

      case (st_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               q_in  = req_if.value[QW-1:0];
               d_in  = DW'(2);
               st_in = ST_START;
            end
         end

         ST_START: begin
            if (q_ff < QW'(2)) begin
               // zero or one: a single empty item
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  factor_in    = '0;
                  last_in      = 1'b1;
                  empty_in     = 1'b1;
                  st_in        = ST_IDLE;
               end
            end else begin
               work_in = q_ff;
               rem_in  = '0;
               cnt_in  = CW'(QW - 1);
               st_in   = ST_DIV;
            end
         end

         ST_DIV: begin
            work_in = {work_ff[QW-2:0], fits};
            rem_in  = fits ? diff[DW-1:0] : trial[DW-1:0];
            if (cnt_ff == '0) begin
               st_in = ST_CHECK;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end

         ST_CHECK: begin
            if (work_ff < d_wide) begin
               // d*d exceeds q: what is left is prime and closes the list
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  factor_in    = FACTOR_W'(q_ff);
                  last_in      = 1'b1;
                  empty_in     = 1'b0;
                  st_in        = ST_IDLE;
               end
            end else if (rem_ff == '0) begin
               // d divides evenly: emit it and keep dividing by the same d
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  factor_in    = FACTOR_W'(d_ff);
                  last_in      = 1'b0;
                  empty_in     = 1'b0;
                  q_in         = work_ff;
                  rem_in       = '0;
                  cnt_in       = CW'(QW - 1);
                  st_in        = ST_DIV;
               end
            end else begin
               // no luck, move on to the next divisor
               d_in    = d_ff + DW'(1);
               work_in = q_ff;
               rem_in  = '0;
               cnt_in  = CW'(QW - 1);
               st_in   = ST_DIV;
            end
         end

         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         d_ff         <= DW'(2);
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         d_ff         <= d_in;
      end
      q_ff      <= q_in;
      work_ff   <= work_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      factor_ff <= factor_in;
      last_ff   <= last_in;
      empty_ff  <= empty_in;
   end

   assign req_if.ready     = (st_ff == ST_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.factor    = factor_ff;
   assign rsp_if.last      = last_ff;
   assign rsp_if.empty_res = empty_ff;

   // trial divisor never drops below two
   a_div_min: assert property (@(posedge clock) disable iff (reset)
      d_ff >= DW'(2))
      else $error("trial divisor below two");

   // an empty item is always the only one and carries a zero factor
   a_empty_fmt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && empty_ff |-> last_ff && (factor_ff == '0))
      else $error("malformed empty item");

   // a real factor is at least two
   a_factor_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !empty_ff |-> factor_ff >= FACTOR_W'(2))
      else $error("factor below two");

   // the quotient holds still while a division runs
   a_q_hold: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DIV) |=> $stable(q_ff))
      else $error("quotient changed during division");

   // partial remainder stays below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DIV) || (st_ff == ST_CHECK) |-> rem_ff < d_ff)
      else $error("remainder out of range");

endmodule : prime_factorizer

`default_nettype wire
